// ===== hdl/bqn_pkg.sv =====
// ============================================================================
// bqn_pkg - shared definitions for the biquad notch filter
// Register map codes and configuration port sizes.
// ============================================================================
package bqn_pkg;

  localparam int NUM_COEFS  = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // Coefficient register index (byte address / 4); codes 5..7 are unmapped
  typedef enum logic [2:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } bqn_reg_t;

endpackage

// ===== hdl/bqn_cfg_regs.sv =====
// ============================================================================
// bqn_cfg_regs - coefficient register file
// APB-style write/read access to the five signed filter coefficients.
// ============================================================================
module bqn_cfg_regs
  import bqn_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 16,
  parameter int COEF_BITS      = 21
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [CFG_ADDR_W-1:0]       addr,
  input  logic [CFG_DATA_W-1:0]       wdata,
  output logic [CFG_DATA_W-1:0]       rdata,
  output logic signed [COEF_BITS-1:0] coef_o [NUM_COEFS]
);

  localparam logic [COEF_BITS-1:0] UNITY = COEF_BITS'(1) << COEF_FRAC_BITS;

  logic signed [COEF_BITS-1:0] coef_r [NUM_COEFS];
  bqn_reg_t                    reg_idx;

  assign reg_idx = bqn_reg_t'(addr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[REG_B0] <= UNITY;
      coef_r[REG_B1] <= '0;
      coef_r[REG_B2] <= '0;
      coef_r[REG_A1] <= '0;
      coef_r[REG_A2] <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_B0:  coef_r[REG_B0] <= wdata[COEF_BITS-1:0];
        REG_B1:  coef_r[REG_B1] <= wdata[COEF_BITS-1:0];
        REG_B2:  coef_r[REG_B2] <= wdata[COEF_BITS-1:0];
        REG_A1:  coef_r[REG_A1] <= wdata[COEF_BITS-1:0];
        REG_A2:  coef_r[REG_A2] <= wdata[COEF_BITS-1:0];
        default: ;  // unmapped address, drop the write
      endcase
    end
  end

  // Read back sign-extended
  always_comb begin
    unique case (reg_idx)
      REG_B0:  rdata = CFG_DATA_W'(coef_r[REG_B0]);
      REG_B1:  rdata = CFG_DATA_W'(coef_r[REG_B1]);
      REG_B2:  rdata = CFG_DATA_W'(coef_r[REG_B2]);
      REG_A1:  rdata = CFG_DATA_W'(coef_r[REG_A1]);
      REG_A2:  rdata = CFG_DATA_W'(coef_r[REG_A2]);
      default: rdata = '0;
    endcase
  end

  assign coef_o = coef_r;

endmodule

// ===== hdl/bqn_datapath.sv =====
// ============================================================================
// bqn_datapath - direct form I multiply-accumulate with delay taps
// Five products, full-width sum, round half up, saturate; holds the taps.
// ============================================================================
module bqn_datapath
  import bqn_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16,
  parameter int COEF_BITS      = 21
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic [SAMPLE_BITS-1:0]      x_i,
  input  logic signed [COEF_BITS-1:0] coef_i [NUM_COEFS],
  output logic [SAMPLE_BITS-1:0]      y_o
);

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int SH_W   = ACC_W - COEF_FRAC_BITS;
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] x1_r, x2_r, y1_r, y2_r;
  logic                          primed_r;
  logic signed [PROD_W-1:0]      p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [ACC_W-1:0]       acc, acc_rnd;
  logic signed [SH_W-1:0]        q;
  logic                          ovf;
  logic [SAMPLE_BITS-1:0]        y_sat;

  assign x = x_i;

  assign p_b0 = x    * coef_i[REG_B0];
  assign p_b1 = x1_r * coef_i[REG_B1];
  assign p_b2 = x2_r * coef_i[REG_B2];
  assign p_a1 = y1_r * coef_i[REG_A1];
  assign p_a2 = y2_r * coef_i[REG_A2];

  assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             - ACC_W'(p_a1) - ACC_W'(p_a2);

  // Round half up, then floor shift by taking the upper bits
  assign acc_rnd = acc + $signed(RND_HALF);
  assign q       = acc_rnd[ACC_W-1:COEF_FRAC_BITS];

  // In range when all bits from the sample sign up agree
  assign ovf   = !(&q[SH_W-1:SAMPLE_BITS-1]) && (|q[SH_W-1:SAMPLE_BITS-1]);
  assign y_sat = ovf ? (q[SH_W-1] ? SAT_MIN : SAT_MAX) : q[SAMPLE_BITS-1:0];

  // Pass the first sample straight through
  assign y_o = primed_r ? y_sat : x_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      x1_r     <= '0;
      x2_r     <= '0;
      y1_r     <= '0;
      y2_r     <= '0;
    end else if (advance) begin
      primed_r <= 1'b1;
      x1_r     <= x;
      y1_r     <= y_o;
      x2_r     <= primed_r ? x1_r : x;
      y2_r     <= primed_r ? y1_r : x;
    end
  end

endmodule

// ===== hdl/biquad_notch_filter.sv =====
// ============================================================================
// biquad_notch_filter - second-order IIR notch filter, direct form I
// Q1.15 samples, Q5.16 coefficients written over an APB-style port.
// ============================================================================
// Path: an input beat is held in the input register, then goes through
//   multiply-accumulate-round-saturate into the output register.
// Throughput: 1 beat per cycle unless the output stalls; taps feed back unpipelined.
// Reset (rst_n low, synchronous): both pipeline stages empty, taps cleared,
//   filter unprimed, b0 = 1.0 and all other coefficients zero.
module biquad_notch_filter
  import bqn_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  // Configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int COEF_BITS = COEF_FRAC_BITS + 5;
  localparam int TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

  // ---------------------------------------------------------------------------
  // Configuration: a write lands on the access phase
  // ---------------------------------------------------------------------------
  logic                        cfg_wr;
  logic signed [COEF_BITS-1:0] coef [NUM_COEFS];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  bqn_cfg_regs #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .COEF_BITS      (COEF_BITS)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cfg_wr),
    .addr   (cfg_paddr),
    .wdata  (cfg_pwdata),
    .rdata  (cfg_prdata),
    .coef_o (coef)
  );

  // ---------------------------------------------------------------------------
  // Two-stage pipeline: input register -> datapath -> output register.
  // The output register decouples the sides, so a waiting result never
  // blocks a new input beat unless both stages are full and stalled.
  // ---------------------------------------------------------------------------
  logic                   s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_data_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_data_r;
  logic                   s1_adv;
  logic                   in_beat;
  logic [SAMPLE_BITS-1:0] y;

  // Advance stage 1 when the output register is empty or being drained
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_beat || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold unless a beat moves in
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_data_r <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (s1_adv) begin
      out_data_r <= y;
    end
  end

  // Taps advance exactly when a sample leaves stage 1
  bqn_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .COEF_BITS      (COEF_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .x_i     (s1_data_r),
    .coef_i  (coef),
    .y_o     (y)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);  // pad upper bits with zeros

endmodule

// ===== hdl/bqn_checker.sv =====
// ============================================================================
// bqn_checker - port-level checks for the biquad notch filter
// Watches the stream handshakes; attached to the top level by bind.
// ============================================================================
module bqn_checker #(
  parameter int TDATA_W = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // With no result pending, the input side is never blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // An accepted beat moves through stage 1 into the output register if the sink drains
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("accepted beat did not reach the output");

endmodule

bind biquad_notch_filter bqn_checker #(
  .TDATA_W (TDATA_W)
) u_bqn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top - testbench for the biquad notch filter
// Drives Q1.15 samples into the input stream and writes Q5.16 coefficients
// over the APB-style port. A local direct form I model predicts every
// output beat. The model covers the first-sample pass-through, half-up
// rounding and saturation. Each output beat is checked in order against the
// oldest prediction. Both streams idle and stall at random.
// ============================================================================
module tb_top;
  import bqn_pkg::*;

  localparam int SMP_W       = 16;
  localparam int COEF_W      = 21;
  localparam int FRAC_W      = 16;
  localparam int WATCHDOG    = 5000;
  localparam int DRAIN_CYC   = 10;
  localparam int NUM_PHASES  = 15;

  // Kinds of coefficient setting used by the random phases
  typedef enum int {
    SET_RANDOM, SET_NOTCH, SET_ALL_MAX, SET_ALL_MIN, SET_ZERO, SET_SMALL
  } coef_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;      // [15:0] sample_in
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;          // [15:0] sample_out
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  biquad_notch_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Filter model: coefficients, delay taps and the primed flag
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0] coef_q [NUM_COEFS];
  logic signed [SMP_W-1:0]  x_d1, x_d2, y_d1, y_d2;
  bit                       taps_primed;

  // Expected output samples, oldest first
  logic signed [SMP_W-1:0]  expected_out_q [$];

  int  error_count = 0;
  int  idle_cycles = 0;
  bit  idle_en = 1'b0;
  int  stall_left = 0;
  int  stall_gap;

  // Advance the model by one sample and return the filtered value
  function automatic logic signed [SMP_W-1:0] filter_sample(logic signed [SMP_W-1:0] x);
    longint acc;
    longint rounded;
    logic signed [SMP_W-1:0] y;
    if (!taps_primed) begin
      // First sample: pass through and fill every tap with it
      x_d1 = x;
      x_d2 = x;
      y_d1 = x;
      y_d2 = x;
      taps_primed = 1'b1;
      return x;
    end
    acc = longint'(coef_q[REG_B0]) * longint'(x)
        + longint'(coef_q[REG_B1]) * longint'(x_d1)
        + longint'(coef_q[REG_B2]) * longint'(x_d2)
        - longint'(coef_q[REG_A1]) * longint'(y_d1)
        - longint'(coef_q[REG_A2]) * longint'(y_d2);
    // Round half up, then clamp to Q1.15
    rounded = (acc + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
    if (rounded > 32767) y = 16'sh7fff;
    else if (rounded < -32768) y = 16'sh8000;
    else y = rounded[SMP_W-1:0];
    x_d2 = x_d1;
    x_d1 = x;
    y_d2 = y_d1;
    y_d1 = y;
    return y;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_val);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
    error_count++;
  endtask

  // Gap length for either side: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Mostly full-range noise, some extremes, some small values
  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 16'($urandom());
    if (r < 80) begin
      case ($urandom_range(0, 4))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h0000;
        3: return 16'hffff;
        default: return 16'h0001;
      endcase
    end
    return 16'($signed($urandom_range(0, 511)) - 256);
  endfunction

  // --------------------------------------------------------------------------
  // Input stream: send one sample beat, predict at acceptance
  // --------------------------------------------------------------------------
  task automatic send_sample(logic [15:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    expected_out_q.push_back(filter_sample(smp));
  endtask

  // Drop valid and wait until every predicted beat has come out
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port: setup cycle, access cycle, then an idle cycle
  // --------------------------------------------------------------------------
  task automatic cfg_write(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    // Unmapped indexes are ignored; bits above the coefficient width too
    if (idx < NUM_COEFS) coef_q[idx] = data[COEF_W-1:0];
  endtask

  task automatic cfg_read(logic [2:0] idx, output logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write one coefficient with random junk above bit 20
  task automatic write_coef(bqn_reg_t r, logic [COEF_W-1:0] val);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom();
    cfg_write(r, {junk[CFG_DATA_W-1:COEF_W], val});
  endtask

  task automatic check_coef(bqn_reg_t r);
    logic [CFG_DATA_W-1:0] rd;
    cfg_read(r, rd);
    if (rd[COEF_W-1:0] !== coef_q[r])
      report_mismatch($sformatf("coefficient read at index %0d", int'(r)),
                      $signed(rd[COEF_W-1:0]), coef_q[r]);
  endtask

  task automatic write_all_coefs(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                                 logic [COEF_W-1:0] b2, logic [COEF_W-1:0] a1,
                                 logic [COEF_W-1:0] a2);
    write_coef(REG_B0, b0);
    write_coef(REG_B1, b1);
    write_coef(REG_B2, b2);
    write_coef(REG_A1, a1);
    write_coef(REG_A2, a2);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values, write and read back, unmapped indexes ignored
  task automatic test_register_access();
    logic [2:0] idx;
    for (int i = 0; i < NUM_COEFS; i++) check_coef(bqn_reg_t'(i));
    write_all_coefs(21'h0fffff, 21'h100000, 21'h155555, 21'h0aaaaa, 21'h1fffff);
    for (int i = 0; i < NUM_COEFS; i++) check_coef(bqn_reg_t'(i));
    for (int i = NUM_COEFS; i < 8; i++) begin
      idx = 3'(i);
      cfg_write(idx, $urandom());
    end
    for (int i = 0; i < NUM_COEFS; i++) check_coef(bqn_reg_t'(i));
  endtask

  // First sample passes through even with odd coefficients loaded
  task automatic test_first_sample();
    write_all_coefs(21'h012345, 21'h1f0000, 21'h008000, 21'h1e4000, 21'h00c000);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_sample(16'hffff);
    send_sample(16'h0001);
    send_sample(16'h5555);
    send_sample(16'haaaa);
    drain_outputs();
  endtask

  // Half-LSB rounding goes up, also for negative sums
  task automatic test_rounding();
    write_all_coefs(21'h008000, 21'h0, 21'h0, 21'h0, 21'h0);
    send_sample(16'h0001);
    send_sample(16'hffff);
    send_sample(16'h0003);
    send_sample(16'hfffd);
    drain_outputs();
  endtask

  // Drive the sum past both rails; the clamped value feeds back
  task automatic test_saturation();
    write_all_coefs(21'h0fffff, 21'h0, 21'h0, 21'h0, 21'h0);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0001);
    drain_outputs();
    write_all_coefs(21'h100000, 21'h0fffff, 21'h100000, 21'h100000, 21'h0fffff);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_sample(16'h7fff);
    send_sample(16'hffff);
    drain_outputs();
  endtask

  // Load one coefficient setting of the given kind
  task automatic load_setting(coef_set_t kind);
    longint c, r;
    case (kind)
      SET_NOTCH: begin
        // Realistic notch: zeros on the unit circle, poles at radius r
        c = longint'($urandom_range(0, 131072)) - 65536;
        r = $urandom_range(52000, 65000);
        write_all_coefs(21'h010000, COEF_W'(-2 * c), 21'h010000,
                        COEF_W'(-((2 * r * c) >>> 16)), COEF_W'((r * r) >>> 16));
      end
      SET_ALL_MAX: write_all_coefs(21'h0fffff, 21'h0fffff, 21'h0fffff,
                                   21'h0fffff, 21'h0fffff);
      SET_ALL_MIN: write_all_coefs(21'h100000, 21'h100000, 21'h100000,
                                   21'h100000, 21'h100000);
      SET_ZERO:    write_all_coefs(21'h0, 21'h0, 21'h0, 21'h0, 21'h0);
      SET_SMALL:   write_all_coefs(COEF_W'($signed($urandom_range(0, 65535)) - 32768),
                                   COEF_W'($signed($urandom_range(0, 65535)) - 32768),
                                   COEF_W'($signed($urandom_range(0, 65535)) - 32768),
                                   COEF_W'($signed($urandom_range(0, 32767)) - 16384),
                                   COEF_W'($signed($urandom_range(0, 32767)) - 16384));
      default:     write_all_coefs(COEF_W'($urandom()), COEF_W'($urandom()),
                                   COEF_W'($urandom()), COEF_W'($urandom()),
                                   COEF_W'($urandom()));
    endcase
    // Now and then hit an unmapped index; it must change nothing
    if ($urandom_range(0, 3) == 0)
      cfg_write(3'($urandom_range(NUM_COEFS, 7)), $urandom());
    for (int i = 0; i < NUM_COEFS; i++) check_coef(bqn_reg_t'(i));
  endtask

  // Random phases: new setting, then a burst of random samples
  task automatic test_random_phases();
    coef_set_t kind;
    int n;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       kind = SET_ALL_MAX;
        1:       kind = SET_ALL_MIN;
        2:       kind = SET_ZERO;
        default: kind = coef_set_t'($urandom_range(SET_RANDOM, SET_SMALL));
      endcase
      load_setting(kind);
      // Hold some phases free of any idling
      idle_en = ($urandom_range(0, 3) != 0);
      n = $urandom_range(60, 140);
      for (int i = 0; i < n; i++) send_sample(pick_sample());
      drain_outputs();
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls and the in-order check of each beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_out_q.size() == 0)
        report_mismatch("unexpected output beat", $signed(out_tdata), 0);
      else if ($signed(out_tdata) !== expected_out_q[0])
        report_mismatch("sample_out", $signed(out_tdata), expected_out_q.pop_front());
      else
        void'(expected_out_q.pop_front());
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_gap = pick_gap();
      if (stall_gap > 0) begin
        stall_left <= stall_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    coef_q[REG_B0] = 21'h010000;
    coef_q[REG_B1] = '0;
    coef_q[REG_B2] = '0;
    coef_q[REG_A1] = '0;
    coef_q[REG_A2] = '0;
    x_d1 = '0;
    x_d2 = '0;
    y_d1 = '0;
    y_d2 = '0;
    taps_primed = 1'b0;

    // Hold reset, then release it for good
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_first_sample();
    idle_en = 1'b1;
    test_rounding();
    test_saturation();
    test_random_phases();

    drain_outputs();
    repeat (DRAIN_CYC) @(posedge clk);
    if (expected_out_q.size() != 0)
      report_mismatch("output beats never delivered", 0, expected_out_q.size());
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
